// ----- hdl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ----- hdl/pist_pkg.sv -----
// -----------------------------------------------------------------------------
// pist_pkg
// Codes, widths and types shared by the held-input set table.
// -----------------------------------------------------------------------------
package pist_pkg;

   localparam int SLOT_COUNT_DEF = 64;
   localparam int ENTRY_W        = 9;   // kind bit above an 8-bit code

   typedef logic [6:0] count_type;
   typedef logic [1:0] req_type_type;
   typedef logic [2:0] status_type;

   localparam req_type_type REQ_PRESS       = 2'd0;
   localparam req_type_type REQ_RELEASE     = 2'd1;
   localparam req_type_type REQ_RELEASE_ALL = 2'd2;

   localparam status_type STAT_ADDED    = 3'd0;
   localparam status_type STAT_HELD     = 3'd1;
   localparam status_type STAT_REMOVED  = 3'd2;
   localparam status_type STAT_MISSING  = 3'd3;
   localparam status_type STAT_FULL     = 3'd4;
   localparam status_type STAT_RELEASED = 3'd5;
   localparam status_type STAT_EMPTY    = 3'd6;

endpackage

// ----- hdl/pressed_input_set_table.sv -----
// -----------------------------------------------------------------------------
// pressed_input_set_table
// Unordered set of held inputs (device kind and code) kept in one RAM.
// -----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Results come on the rsp_
// ports for one cycle each, marked by rsp_valid, and cannot be held off. Full
// on press and an empty release-all answer without leaving idle; an unused
// code gives no result. With n entries held, press and release scan the
// RAM one slot per cycle through its single read port: a press hit answers
// once its read returns, a release hit first moves the last entry over the
// hit slot, a miss after all n reads, or with no read on an empty table.
// Release-all streams n results on consecutive cycles.
// The RAM needs no clearing after reset; only data from slots below the count is used.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pressed_input_set_table #(
   parameter int SLOT_COUNT = pist_pkg::SLOT_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic                     req_dev_kind,
   input  logic [7:0]               req_key_code,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic                     rsp_entry_kind,
   output logic [7:0]               rsp_entry_code,
   output logic [6:0]               rsp_held_count,
   output logic                     rsp_last
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int EW    = pist_pkg::ENTRY_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_MOVE_RD = 3'd2;
   localparam logic [2:0] S_MOVE_WR = 3'd3;
   localparam logic [2:0] S_DUMP    = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pidx_ff, pidx_in;
   logic [IDX_W-1:0]       hit_ff, hit_in;
   logic [1:0]             op_ff, op_in;
   logic                   kind_ff, kind_in;
   logic [7:0]             code_ff, code_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [7:0]             rsp_code_ff, rsp_code_in;
   logic [6:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [EW-1:0]          wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [EW-1:0]          rd_data;

   logic                   issue;
   logic                   match;
   logic [CNT_W-1:0]       remain;

   pist_ram #(
      .WIDTH (EW),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign issue  = (scan_ff < cnt_ff);
   assign match  = pend_ff && (rd_data == {kind_ff, code_ff});
   assign remain = cnt_ff - CNT_W'(pidx_ff) - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      op_in         = op_ff;
      kind_in       = kind_ff;
      code_in       = code_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      wr_data       = {kind_ff, code_ff};
      rd_addr       = scan_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in       = req_type;
               kind_in     = req_dev_kind;
               code_in     = req_key_code;
               scan_in     = '0;
               rsp_kind_in = req_dev_kind;
               rsp_code_in = req_key_code;
               case (req_type)
                  pist_pkg::REQ_PRESS: begin
                     if (cnt_ff >= CNT_W'(SLOT_COUNT)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = pist_pkg::STAT_FULL;
                        rsp_count_in  = pist_pkg::count_type'(cnt_ff);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  pist_pkg::REQ_RELEASE: begin
                     state_in = S_SCAN;
                  end
                  pist_pkg::REQ_RELEASE_ALL: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = pist_pkg::STAT_EMPTY;
                        rsp_count_in  = '0;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end
            if (match) begin
               pend_in = 1'b0;
               if (op_ff == pist_pkg::REQ_PRESS) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = pist_pkg::STAT_HELD;
                  rsp_count_in  = pist_pkg::count_type'(cnt_ff);
                  state_in      = S_IDLE;
               end else begin
                  hit_in   = pidx_ff;
                  state_in = S_MOVE_RD;
               end
            end else if (!issue && !pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == pist_pkg::REQ_PRESS) begin
                  wr_en         = 1'b1;
                  cnt_in        = cnt_ff + CNT_W'(1);
                  rsp_status_in = pist_pkg::STAT_ADDED;
                  rsp_count_in  = pist_pkg::count_type'(cnt_ff + CNT_W'(1));
               end else begin
                  rsp_status_in = pist_pkg::STAT_MISSING;
                  rsp_count_in  = pist_pkg::count_type'(cnt_ff);
               end
            end
         end
         S_MOVE_RD: begin
            rd_addr  = IDX_W'(cnt_ff - CNT_W'(1));
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en         = 1'b1;
            wr_addr       = hit_ff;
            wr_data       = rd_data;
            cnt_in        = cnt_ff - CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_status_in = pist_pkg::STAT_REMOVED;
            rsp_count_in  = pist_pkg::count_type'(cnt_ff - CNT_W'(1));
            state_in      = S_IDLE;
         end
         S_DUMP: begin
            if (issue) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pist_pkg::STAT_RELEASED;
               rsp_kind_in   = rd_data[EW-1];
               rsp_code_in   = rd_data[EW-2:0];
               rsp_count_in  = pist_pkg::count_type'(remain);
               if (remain == '0) begin
                  rsp_last_in = 1'b1;
                  pend_in     = 1'b0;
                  cnt_in      = '0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      op_ff         <= op_in;
      kind_ff       <= kind_in;
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_kind = rsp_kind_ff;
   assign rsp_entry_code = rsp_code_ff;
   assign rsp_held_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CNT_W'(SLOT_COUNT))
   `ASSERT_HOLDS(a_last_idle, clock, reset, (rsp_valid_ff && rsp_last_ff) |-> !busy)
   `ASSERT_HOLDS(a_dump_stream, clock, reset, (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
   `ASSERT_HOLDS(a_partial_dump, clock, reset, (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == S_DUMP))

endmodule

// ----- hdl/pist_ram.sv -----
// -----------------------------------------------------------------------------
// pist_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module pist_ram #(
   parameter int WIDTH = pist_pkg::ENTRY_W,
   parameter int DEPTH = pist_pkg::SLOT_COUNT_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/pressed_input_set_table_test.sv -----
// -----------------------------------------------------------------------------
// pressed_input_set_table_test
// Self-checking bench for the held-input set table: a scoreboard class keeps
// its own copy of the held set, predicts every result of each accepted word
// and compares the results as they stream out. Stimulus runs a directed
// pass over the corner cases, then table-fill episodes and mixed
// press/release traffic under three sender idling profiles.
// -----------------------------------------------------------------------------
module pressed_input_set_table_test;

   localparam int                     SLOTS       = pist_pkg::SLOT_COUNT_DEF;
   localparam pist_pkg::req_type_type REQ_UNUSED  = 2'd3;
   localparam int                     STALL_LIMIT = 4000;
   localparam int                     PHASE_ITEMS = 120;

   typedef struct packed {
      pist_pkg::status_type status;
      logic                 kind;
      logic [7:0]           code;
      pist_pkg::count_type  count;
      logic                 last;
   } held_result_type;

   class held_set_scoreboard;
      held_result_type pending_results[$];
      logic            held_kind [SLOTS];
      logic [7:0]      held_code [SLOTS];
      int              held_n;
      int              errors;
      int              results_seen;
      int              ignored_words;

      function new();
         held_n        = 0;
         errors        = 0;
         results_seen  = 0;
         ignored_words = 0;
      endfunction

      function int find_entry(logic kind, logic [7:0] code);
         for (int i = 0; i < held_n; i++) begin
            if (held_kind[i] == kind && held_code[i] == code) begin
               return i;
            end
         end
         return -1;
      endfunction

      function void push_result(pist_pkg::status_type st, logic kind, logic [7:0] code,
                                int cnt, logic last);
         held_result_type r;
         r.status = st;
         r.kind   = kind;
         r.code   = code;
         r.count  = pist_pkg::count_type'(cnt);
         r.last   = last;
         pending_results.push_back(r);
      endfunction

      function void note_word(pist_pkg::req_type_type rt, logic kind, logic [7:0] code);
         int n;
         int hit;
         n = held_n;
         case (rt)
            pist_pkg::REQ_PRESS: begin
               if (n >= SLOTS) begin
                  push_result(pist_pkg::STAT_FULL, kind, code, n, 1'b1);
               end else if (find_entry(kind, code) >= 0) begin
                  push_result(pist_pkg::STAT_HELD, kind, code, n, 1'b1);
               end else begin
                  held_kind[n] = kind;
                  held_code[n] = code;
                  held_n       = n + 1;
                  push_result(pist_pkg::STAT_ADDED, kind, code, held_n, 1'b1);
               end
            end
            pist_pkg::REQ_RELEASE: begin
               hit = find_entry(kind, code);
               if (hit < 0) begin
                  push_result(pist_pkg::STAT_MISSING, kind, code, n, 1'b1);
               end else begin
                  held_kind[hit] = held_kind[n - 1];
                  held_code[hit] = held_code[n - 1];
                  held_n         = n - 1;
                  push_result(pist_pkg::STAT_REMOVED, kind, code, held_n, 1'b1);
               end
            end
            pist_pkg::REQ_RELEASE_ALL: begin
               if (n == 0) begin
                  push_result(pist_pkg::STAT_EMPTY, kind, code, 0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     push_result(pist_pkg::STAT_RELEASED, held_kind[i], held_code[i],
                                 n - i - 1, i + 1 == n);
                  end
               end
               held_n = 0;
            end
            default: begin
               ignored_words++;
            end
         endcase
      endfunction

      function void compare_field(string name, int expected, int actual);
         if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            errors++;
         end
      endfunction

      function void check_result(pist_pkg::status_type st, logic kind, logic [7:0] code,
                                 pist_pkg::count_type cnt, logic last);
         held_result_type r;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: status %0d code %0d", st, code);
            errors++;
         end else begin
            r = pending_results.pop_front();
            compare_field("status", r.status, st);
            compare_field("entry_kind", r.kind, kind);
            compare_field("entry_code", r.code, code);
            compare_field("held_count", r.count, cnt);
            compare_field("last", r.last, last);
         end
      endfunction

      function void finish_check();
         if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   pist_pkg::req_type_type req_type = pist_pkg::REQ_PRESS;
   logic                   req_dev_kind = 1'b0;
   logic [7:0]             req_key_code = 8'd0;
   logic                   rsp_valid;
   pist_pkg::status_type   rsp_status;
   logic                   rsp_entry_kind;
   logic [7:0]             rsp_entry_code;
   pist_pkg::count_type    rsp_held_count;
   logic                   rsp_last;

   held_set_scoreboard sb = new();
   int idle_pct    = 0;
   int items       = 0;
   int fill_runs   = 0;
   int stall_count = 0;

   pressed_input_set_table DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_dev_kind   (req_dev_kind),
      .req_key_code   (req_key_code),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_entry_kind (rsp_entry_kind),
      .rsp_entry_code (rsp_entry_code),
      .rsp_held_count (rsp_held_count),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_word(req_type, req_dev_kind, req_key_code);
         end
         if (rsp_valid) begin
            sb.check_result(rsp_status, rsp_entry_kind, rsp_entry_code, rsp_held_count,
                            rsp_last);
         end
         if ((start && !busy) || rsp_valid) begin
            stall_count <= 0;
         end else if (stall_count + 1 >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   task automatic send_word(input pist_pkg::req_type_type rt, input logic kind,
                            input logic [7:0] code);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 24) begin
         gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_type     <= rt;
      req_dev_kind <= kind;
      req_key_code <= code;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (rt != REQ_UNUSED) begin
         items++;
      end
   endtask

   // drop start and hold until every expected result is back
   task automatic wait_drained(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic fill_run();
      logic       kb;
      logic [7:0] base;
      kb   = 1'($urandom_range(1));
      base = 8'($urandom_range(255));
      fill_runs++;
      send_word(pist_pkg::REQ_RELEASE_ALL, 1'($urandom_range(1)), 8'($urandom_range(255)));
      for (int i = 0; i < SLOTS; i++) begin
         send_word(pist_pkg::REQ_PRESS, kb ^ 1'(i), base + 8'(i >> 1));
      end
      send_word(pist_pkg::REQ_PRESS, kb, base);
      send_word(pist_pkg::REQ_PRESS, ~kb, base + 8'd31);
      send_word(pist_pkg::REQ_PRESS, kb, base + 8'd100);
      send_word(pist_pkg::REQ_PRESS, ~kb, base + 8'd200);
      send_word(pist_pkg::REQ_RELEASE, kb ^ 1'($urandom_range(1)),
                base + 8'($urandom_range(31)));
      send_word(pist_pkg::REQ_PRESS, kb, base + 8'd77);
      send_word(pist_pkg::REQ_PRESS, ~kb, base + 8'd77);
      send_word(pist_pkg::REQ_RELEASE_ALL, 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   task automatic mixed_run(input int count);
      int                     pool;
      int                     r;
      logic [7:0]             base;
      logic [7:0]             code;
      pist_pkg::req_type_type rt;
      pool = ($urandom_range(4) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 20);
      base = 8'($urandom_range(255));
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 58) begin
            rt = pist_pkg::REQ_PRESS;
         end else if (r < 88) begin
            rt = pist_pkg::REQ_RELEASE;
         end else if (r < 95) begin
            rt = pist_pkg::REQ_RELEASE_ALL;
         end else begin
            rt = REQ_UNUSED;
         end
         if ($urandom_range(9) == 0) begin
            code = 8'($urandom_range(255));
         end else begin
            code = base + 8'($urandom_range(pool - 1));
         end
         send_word(rt, 1'($urandom_range(1)), code);
      end
   endtask

   initial begin
      int phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 32;
      send_word(pist_pkg::REQ_RELEASE_ALL, 1'b1, 8'hFF);
      send_word(pist_pkg::REQ_RELEASE, 1'b1, 8'h00);
      send_word(pist_pkg::REQ_PRESS, 1'b0, 8'h00);
      send_word(pist_pkg::REQ_PRESS, 1'b1, 8'hFF);
      send_word(pist_pkg::REQ_PRESS, 1'b0, 8'hFF);
      send_word(pist_pkg::REQ_PRESS, 1'b1, 8'h00);
      send_word(pist_pkg::REQ_PRESS, 1'b0, 8'h00);
      send_word(pist_pkg::REQ_PRESS, 1'b1, 8'hAA);
      send_word(pist_pkg::REQ_PRESS, 1'b0, 8'h55);
      send_word(pist_pkg::REQ_RELEASE, 1'b1, 8'hFF);
      send_word(pist_pkg::REQ_RELEASE, 1'b1, 8'hFF);
      send_word(REQ_UNUSED, 1'b1, 8'hFF);
      send_word(pist_pkg::REQ_RELEASE, 1'b0, 8'h55);
      send_word(pist_pkg::REQ_RELEASE_ALL, 1'b0, 8'h00);
      send_word(pist_pkg::REQ_RELEASE_ALL, 1'b0, 8'h00);
      send_word(pist_pkg::REQ_PRESS, 1'b1, 8'h5A);
      send_word(REQ_UNUSED, 1'b0, 8'h00);
      send_word(pist_pkg::REQ_RELEASE, 1'b1, 8'h5A);
      wait_drained(8);

      for (int p = 0; p < 3; p++) begin
         idle_pct    = (p == 0) ? 32 : (p == 1) ? 45 : 0;
         phase_start = items;
         fill_run();
         while (items - phase_start < PHASE_ITEMS) begin
            mixed_run($urandom_range(10, 40));
         end
         wait_drained(8);
      end

      wait_drained(80);
      sb.finish_check();
      $display("Covered %0d words (%0d ignored) and %0d results, %0d full-table episodes",
               items, sb.ignored_words, sb.results_seen, fill_runs);
      $display("Sender idle profiles 32, 45 and 0 percent, drained between phases");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
